// ===== rtl/e2cd_pkg.sv =====
// Package for the epoch-to-calendar converter: shared types, stage counts
// and the reciprocal constants used for division by constants. No dependencies.

package e2cd_pkg;

  // time-of-day fields carried alongside the date pipeline
  typedef struct packed {
    logic [5:0] sec;
    logic [5:0] min;
    logic [4:0] hour;
  } hms_t;

  localparam int unsigned TIME_STAGES = 6;
  localparam int unsigned DATE_STAGES = 9;

  // largest day count a 32-bit second count can reach
  localparam logic [15:0] MAX_DAYS = 16'd49710;

  // floor(n/60) = (n * DIV60_MAGIC) >> 37, exact for any 32-bit n
  localparam logic [31:0] DIV60_MAGIC = 32'h8888_8889;
  // floor(n/24) = (n * DIV24_MAGIC) >> 36, exact for any 32-bit n
  localparam logic [31:0] DIV24_MAGIC = 32'hAAAA_AAAB;

  // a = (4t + 102032) / 146097 + 15 only takes 15..17
  localparam logic [18:0] A_OFFSET = 19'd102032;
  localparam logic [18:0] A_STEP2  = 19'd292194;
  // 2442113 + a - a/4 with a = 15 or 16
  localparam logic [21:0] B_BASE   = 22'd2442125;

  // c = (20b - 2442) / 7305 = (x * C_MAGIC) >> 39 for x < 2^26
  localparam logic [25:0] C_OFFSET = 26'd2442;
  localparam logic [26:0] C_MAGIC  = 27'd75257470;
  // e = d * 1000 / 30601 = (d * E_MAGIC) >> 30 for d < 1024
  localparam logic [25:0] E_MAGIC  = 26'd35088456;
  // e * 601 / 1000 = (e * G_MAGIC) >> 16 for e < 64
  localparam logic [15:0] G_MAGIC  = 16'd39388;

  localparam logic [12:0] YEAR_BIAS_LO = 13'd4716;
  localparam logic [12:0] YEAR_BIAS_HI = 13'd4715;

endpackage

// ===== rtl/e2cd_time_split.sv =====
// Splits a 32-bit second count into seconds, minutes, hours and a day count.
// Six-stage pipeline with a per-stage ready chain; uses e2cd_pkg.

module e2cd_time_split import e2cd_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        valid_i,
  output logic        ready_o,
  input  logic [31:0] epoch_i,
  output logic        valid_o,
  input  logic        ready_i,
  output logic [15:0] days_o,
  output hms_t        hms_o
);

  logic [TIME_STAGES-1:0] valid_q;
  logic [TIME_STAGES-1:0] valid_in;
  logic [TIME_STAGES:0]   stage_rdy;

  // stage 0: t * 1/60
  logic [31:0] t0_q;
  logic [63:0] p0_d, p0_q;
  // stage 1: minutes count, seconds
  logic [26:0] m1_d, m1_q;
  logic [5:0]  sec1_d, sec1_q;
  // stage 2: minutes * 1/60
  logic [57:0] p2_d, p2_q;
  logic [26:0] m2_q;
  logic [5:0]  sec2_q;
  // stage 3: hours count, minutes
  logic [20:0] h3_d, h3_q;
  logic [5:0]  min3_d, min3_q, sec3_q;
  // stage 4: hours * 1/24
  logic [51:0] p4_d, p4_q;
  logic [20:0] h4_q;
  logic [5:0]  min4_q, sec4_q;
  // stage 5: day count, hour
  logic [15:0] days5_d, days5_q;
  hms_t        hms5_d, hms5_q;

  // a stage takes a new word when it is empty or its content moves on
  always_comb begin
    stage_rdy[TIME_STAGES] = ready_i;
    for (int k = TIME_STAGES - 1; k >= 0; k--) begin
      stage_rdy[k] = !valid_q[k] || stage_rdy[k+1];
    end
  end

  assign valid_in = {valid_q[TIME_STAGES-2:0], valid_i};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else begin
      for (int k = 0; k < TIME_STAGES; k++) begin
        if (stage_rdy[k]) begin
          valid_q[k] <= valid_in[k];
        end
      end
    end
  end

  assign p0_d    = 64'(epoch_i) * 64'(DIV60_MAGIC);
  assign m1_d    = p0_q[63:37];
  assign sec1_d  = 6'(t0_q - 32'(m1_d) * 32'd60);
  assign p2_d    = 58'(m1_q) * 58'(DIV60_MAGIC);
  assign h3_d    = p2_q[57:37];
  assign min3_d  = 6'(m2_q - 27'(h3_d) * 27'd60);
  assign p4_d    = 52'(h3_q) * 52'(DIV24_MAGIC);
  assign days5_d = p4_q[51:36];

  always_comb begin
    hms5_d.sec  = sec4_q;
    hms5_d.min  = min4_q;
    hms5_d.hour = 5'(h4_q - 21'(days5_d) * 21'd24);
  end

  always_ff @(posedge clk_i) begin
    if (stage_rdy[0]) begin
      t0_q <= epoch_i;
      p0_q <= p0_d;
    end
    if (stage_rdy[1]) begin
      m1_q   <= m1_d;
      sec1_q <= sec1_d;
    end
    if (stage_rdy[2]) begin
      p2_q   <= p2_d;
      m2_q   <= m1_q;
      sec2_q <= sec1_q;
    end
    if (stage_rdy[3]) begin
      h3_q   <= h3_d;
      min3_q <= min3_d;
      sec3_q <= sec2_q;
    end
    if (stage_rdy[4]) begin
      p4_q   <= p4_d;
      h4_q   <= h3_q;
      min4_q <= min3_q;
      sec4_q <= sec3_q;
    end
    if (stage_rdy[5]) begin
      days5_q <= days5_d;
      hms5_q  <= hms5_d;
    end
  end

  assign ready_o = stage_rdy[0];
  assign valid_o = valid_q[TIME_STAGES-1];
  assign days_o  = days5_q;
  assign hms_o   = hms5_q;

endmodule

// ===== rtl/e2cd_date_calc.sv =====
// Turns a day count since 1970-01-01 into year, month, day and ISO weekday.
// Nine-stage pipeline with a per-stage ready chain; uses e2cd_pkg.

module e2cd_date_calc import e2cd_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        valid_i,
  output logic        ready_o,
  input  logic [15:0] days_i,
  input  hms_t        hms_i,
  output logic        valid_o,
  input  logic        ready_i,
  output hms_t        hms_o,
  output logic [11:0] year_o,
  output logic [3:0]  month_o,
  output logic [4:0]  day_o,
  output logic [2:0]  weekday_o
);

  typedef struct packed {
    logic [11:0] year;
    logic [3:0]  month;
    logic [4:0]  day;
  } ymd_t;

  // (26 * (m + 1)) / 10 for the shifted month 3..14
  function automatic logic [5:0] month_term(input logic [3:0] m);
    logic [5:0] r;
    case (m)
      4'd3:    r = 6'd10;
      4'd4:    r = 6'd13;
      4'd5:    r = 6'd15;
      4'd6:    r = 6'd18;
      4'd7:    r = 6'd20;
      4'd8:    r = 6'd23;
      4'd9:    r = 6'd26;
      4'd10:   r = 6'd28;
      4'd11:   r = 6'd31;
      4'd12:   r = 6'd33;
      4'd13:   r = 6'd36;
      4'd14:   r = 6'd39;
      default: r = 6'd0;
    endcase
    return r;
  endfunction

  logic [DATE_STAGES-1:0] valid_q;
  logic [DATE_STAGES-1:0] valid_in;
  logic [DATE_STAGES:0]   stage_rdy;
  hms_t                   hms_q [DATE_STAGES];

  logic [18:0] a_sum;
  logic [21:0] b0_d, b0_q, b1_q;
  logic [25:0] cx;
  logic [51:0] pc1_d, pc1_q;
  logic [12:0] c2_d, c2_q, c3_q, c4_q;
  logic [9:0]  d2_d, d2_q, d3_q, d4_q;
  logic [35:0] pe3_d, pe3_q;
  logic [5:0]  e4_d, e4_q;
  logic [21:0] pg4_d, pg4_q;
  logic [5:0]  g5;
  ymd_t        ymd5_d, ymd5_q, ymd6_q, ymd7_q, ymd8_q;
  logic [11:0] yz6;
  logic [3:0]  mz6_d, mz6_q;
  logic [4:0]  cent6_d, cent6_q;
  logic [6:0]  yoc6_d, yoc6_q;
  logic [8:0]  h7_d, h7_q;
  logic [8:0]  wv;
  logic [4:0]  fold1;
  logic [3:0]  fold2;
  logic [2:0]  wd8_d, wd8_q;

  always_comb begin
    stage_rdy[DATE_STAGES] = ready_i;
    for (int k = DATE_STAGES - 1; k >= 0; k--) begin
      stage_rdy[k] = !valid_q[k] || stage_rdy[k+1];
    end
  end

  assign valid_in = {valid_q[DATE_STAGES-2:0], valid_i};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else begin
      for (int k = 0; k < DATE_STAGES; k++) begin
        if (stage_rdy[k]) begin
          valid_q[k] <= valid_in[k];
        end
      end
    end
  end

  // a - a/4 is 12 unless a reaches 17
  assign a_sum = {days_i, 2'b00} + A_OFFSET;
  assign b0_d  = 22'(days_i) + B_BASE + 22'(a_sum >= A_STEP2);

  assign cx    = 26'(b0_q) * 26'd20 - C_OFFSET;
  assign pc1_d = 52'(cx) * 52'(C_MAGIC);

  assign c2_d  = pc1_q[51:39];
  assign d2_d  = 10'(b1_q - 22'(c2_d) * 22'd365 - 22'(c2_d[12:2]));

  assign pe3_d = 36'(d2_q) * 36'(E_MAGIC);

  assign e4_d  = pe3_q[35:30];
  assign pg4_d = 22'(e4_d) * 22'(G_MAGIC);

  // months 14 and 15 of the shifted year are January and February
  assign g5 = pg4_q[21:16];
  always_comb begin
    ymd5_d.day = 5'(10'(d4_q) - 10'(e4_q) * 10'd30 - 10'(g5));
    if (e4_q <= 6'd13) begin
      ymd5_d.year  = 12'(c4_q - YEAR_BIAS_LO);
      ymd5_d.month = 4'(e4_q - 6'd1);
    end else begin
      ymd5_d.year  = 12'(c4_q - YEAR_BIAS_HI);
      ymd5_d.month = 4'(e4_q - 6'd13);
    end
  end

  // Zeller: January and February belong to the previous year
  always_comb begin
    if (ymd5_q.month <= 4'd2) begin
      mz6_d = ymd5_q.month + 4'd12;
      yz6   = ymd5_q.year - 12'd1;
    end else begin
      mz6_d = ymd5_q.month;
      yz6   = ymd5_q.year;
    end
    if (yz6 < 12'd2000) begin
      cent6_d = 5'd19;
    end else if (yz6 < 12'd2100) begin
      cent6_d = 5'd20;
    end else begin
      cent6_d = 5'd21;
    end
    yoc6_d = 7'(yz6 - 12'(cent6_d) * 12'd100);
  end

  assign h7_d = 9'(ymd6_q.day) + 9'(month_term(mz6_q)) + 9'(yoc6_q) + 9'(yoc6_q[6:2])
              + 9'(cent6_q) * 9'd5 + 9'(cent6_q[4:2]);

  // (h + 5) mod 7 by folding octal digits, since 8 = 1 mod 7
  always_comb begin
    wv    = h7_q + 9'd5;
    fold1 = 5'(wv[8:6]) + 5'(wv[5:3]) + 5'(wv[2:0]);
    fold2 = 4'(fold1[4:3]) + 4'(fold1[2:0]);
    if (fold2 >= 4'd7) begin
      wd8_d = 3'(fold2 - 4'd7) + 3'd1;
    end else begin
      wd8_d = fold2[2:0] + 3'd1;
    end
  end

  always_ff @(posedge clk_i) begin
    for (int k = 0; k < DATE_STAGES; k++) begin
      if (stage_rdy[k]) begin
        hms_q[k] <= (k == 0) ? hms_i : hms_q[(k == 0) ? 0 : k - 1];
      end
    end
    if (stage_rdy[0]) begin
      b0_q <= b0_d;
    end
    if (stage_rdy[1]) begin
      pc1_q <= pc1_d;
      b1_q  <= b0_q;
    end
    if (stage_rdy[2]) begin
      c2_q <= c2_d;
      d2_q <= d2_d;
    end
    if (stage_rdy[3]) begin
      pe3_q <= pe3_d;
      c3_q  <= c2_q;
      d3_q  <= d2_q;
    end
    if (stage_rdy[4]) begin
      e4_q  <= e4_d;
      pg4_q <= pg4_d;
      c4_q  <= c3_q;
      d4_q  <= d3_q;
    end
    if (stage_rdy[5]) begin
      ymd5_q <= ymd5_d;
    end
    if (stage_rdy[6]) begin
      ymd6_q  <= ymd5_q;
      mz6_q   <= mz6_d;
      cent6_q <= cent6_d;
      yoc6_q  <= yoc6_d;
    end
    if (stage_rdy[7]) begin
      ymd7_q <= ymd6_q;
      h7_q   <= h7_d;
    end
    if (stage_rdy[8]) begin
      ymd8_q <= ymd7_q;
      wd8_q  <= wd8_d;
    end
  end

  assign ready_o   = stage_rdy[0];
  assign valid_o   = valid_q[DATE_STAGES-1];
  assign hms_o     = hms_q[DATE_STAGES-1];
  assign year_o    = ymd8_q.year;
  assign month_o   = ymd8_q.month;
  assign day_o     = ymd8_q.day;
  assign weekday_o = wd8_q;

endmodule

// ===== rtl/epoch_to_calendar_date.sv =====
// Unix time to Gregorian date, time of day and ISO weekday (1 Monday .. 7 Sunday).
// Top level; instantiates e2cd_time_split and e2cd_date_calc, uses e2cd_pkg.
// A word passes through 6 stages of time split and 9 of date arithmetic, and one
// word can enter every cycle unless the pipeline is full. Each stage holds its
// own valid bit and loads when it is empty or its content moves on, so a stalled
// output only blocks the input once every stage is full. No configuration and no
// state beyond the pipeline; every 32-bit input gives a result in range.

module epoch_to_calendar_date import e2cd_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [31:0] epoch_seconds_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [5:0]  sec_out_o,
  output logic [5:0]  min_out_o,
  output logic [4:0]  hour_out_o,
  output logic [11:0] year_out_o,
  output logic [3:0]  month_out_o,
  output logic [4:0]  day_out_o,
  output logic [2:0]  weekday_out_o
);

  logic        mid_valid;
  logic        mid_ready;
  logic [15:0] mid_days;
  hms_t        mid_hms;
  hms_t        out_hms;

  e2cd_time_split u_time (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (in_valid_i),
    .ready_o (in_ready_o),
    .epoch_i (epoch_seconds_i),
    .valid_o (mid_valid),
    .ready_i (mid_ready),
    .days_o  (mid_days),
    .hms_o   (mid_hms)
  );

  e2cd_date_calc u_date (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .valid_i   (mid_valid),
    .ready_o   (mid_ready),
    .days_i    (mid_days),
    .hms_i     (mid_hms),
    .valid_o   (out_valid_o),
    .ready_i   (out_ready_i),
    .hms_o     (out_hms),
    .year_o    (year_out_o),
    .month_o   (month_out_o),
    .day_o     (day_out_o),
    .weekday_o (weekday_out_o)
  );

  assign sec_out_o  = out_hms.sec;
  assign min_out_o  = out_hms.min;
  assign hour_out_o = out_hms.hour;

  // backpressure at the input only when the output is stalled
  a_stall_source: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> out_valid_o && !out_ready_i)
    else $error("input stalled without a stalled output");

  a_days_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mid_valid |-> mid_days <= MAX_DAYS)
    else $error("day count out of range");

  a_out_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> sec_out_o < 6'd60 && min_out_o < 6'd60 && hour_out_o < 5'd24
      && month_out_o >= 4'd1 && month_out_o <= 4'd12 && day_out_o >= 5'd1
      && weekday_out_o >= 3'd1 && year_out_o >= 12'd1970 && year_out_o <= 12'd2106)
    else $error("result field out of range");

endmodule
